// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the hypergeometric tail inverse block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds
`define HGTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds
`define HGTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hgti_pkg.sv =====
// Shared types, codes and the microprogram of the hypergeometric tail inverse block
package hgti_pkg;

  localparam int FIELD_W   = 6;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_POP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE = 2'd1;

  typedef logic [PC_W-1:0] step_t;

  localparam step_t STEP_IDLE     = 5'd0;
  localparam step_t STEP_CHECK    = 5'd1;
  localparam step_t STEP_R_LO     = 5'd2;
  localparam step_t STEP_R_HI     = 5'd3;
  localparam step_t STEP_R_SUM    = 5'd4;
  localparam step_t STEP_SUM_INIT = 5'd5;
  localparam step_t STEP_TERM_RD  = 5'd6;
  localparam step_t STEP_TERM_LL  = 5'd7;
  localparam step_t STEP_TERM_LH  = 5'd8;
  localparam step_t STEP_TERM_HL  = 5'd9;
  localparam step_t STEP_TERM_ACC = 5'd10;
  localparam step_t STEP_CMP      = 5'd11;
  localparam step_t STEP_NEXT_M   = 5'd12;
  localparam step_t STEP_EMIT     = 5'd13;
  localparam step_t STEP_RET      = 5'd14;
  localparam step_t STEP_EMIT_BAD = 5'd15;
  localparam step_t STEP_RET_BAD  = 5'd16;

  typedef struct packed {
    logic [FIELD_W-1:0] success_count;
    logic [FRAC_W-1:0]  threshold_fraction;
  } hgti_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] smallest_m;
    logic               bad_query;
  } hgti_out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_RD_TOTAL,
    OP_MUL_R_LO,
    OP_MUL_R_HI,
    OP_ACC_R,
    OP_SUM_INIT,
    OP_RD_TERM,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_MUL_HL,
    OP_ACC_NEXT_T,
    OP_INC_M,
    OP_EMIT,
    OP_EMIT_BAD
  } dp_op_t;

  typedef enum logic [3:0] {
    JMP_NONE,
    JMP_GOTO,
    JMP_NO_ACCEPT,
    JMP_BAD,
    JMP_LO_ABOVE_S,
    JMP_T_BELOW_S,
    JMP_FITS,
    JMP_M_BELOW_L,
    JMP_OUT_BUSY
  } jump_t;

  typedef struct packed {
    dp_op_t op;
    jump_t  jump;
    step_t  target;
  } uword_t;

  typedef struct packed {
    logic bad;
    logic lo_above_s;
    logic t_below_s;
    logic fits;
    logic m_below_l;
  } dp_flags_t;

  typedef struct packed {
    logic      accept;
    logic      out_busy;
    dp_flags_t dp;
  } seq_flags_t;

  // Microprogram: one control word per step, jump taken when its condition holds
  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE:     w = '{OP_LATCH,      JMP_NO_ACCEPT,  STEP_IDLE};
      STEP_CHECK:    w = '{OP_RD_TOTAL,   JMP_BAD,        STEP_EMIT_BAD};
      STEP_R_LO:     w = '{OP_MUL_R_LO,   JMP_NONE,       STEP_IDLE};
      STEP_R_HI:     w = '{OP_MUL_R_HI,   JMP_NONE,       STEP_IDLE};
      STEP_R_SUM:    w = '{OP_ACC_R,      JMP_NONE,       STEP_IDLE};
      STEP_SUM_INIT: w = '{OP_SUM_INIT,   JMP_LO_ABOVE_S, STEP_CMP};
      STEP_TERM_RD:  w = '{OP_RD_TERM,    JMP_NONE,       STEP_IDLE};
      STEP_TERM_LL:  w = '{OP_MUL_LL,     JMP_NONE,       STEP_IDLE};
      STEP_TERM_LH:  w = '{OP_MUL_LH,     JMP_NONE,       STEP_IDLE};
      STEP_TERM_HL:  w = '{OP_MUL_HL,     JMP_NONE,       STEP_IDLE};
      STEP_TERM_ACC: w = '{OP_ACC_NEXT_T, JMP_T_BELOW_S,  STEP_TERM_RD};
      STEP_CMP:      w = '{OP_NOP,        JMP_FITS,       STEP_EMIT};
      STEP_NEXT_M:   w = '{OP_INC_M,      JMP_M_BELOW_L,  STEP_SUM_INIT};
      STEP_EMIT:     w = '{OP_EMIT,       JMP_OUT_BUSY,   STEP_EMIT};
      STEP_RET:      w = '{OP_NOP,        JMP_GOTO,       STEP_IDLE};
      STEP_EMIT_BAD: w = '{OP_EMIT_BAD,   JMP_OUT_BUSY,   STEP_EMIT_BAD};
      STEP_RET_BAD:  w = '{OP_NOP,        JMP_GOTO,       STEP_IDLE};
      default:       w = '{OP_NOP,        JMP_GOTO,       STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/hgti_binom_rom.sv =====
// Binomial coefficient memory, filled with Pascal's triangle after reset
module hgti_binom_rom #(
  parameter int MAX_TOTAL = 50,
  localparam int IW = $clog2(MAX_TOTAL + 1),
  localparam int BW = MAX_TOTAL
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [IW-1:0] a_n,
  input  logic [IW-1:0] a_r,
  input  logic [IW-1:0] b_n,
  input  logic [IW-1:0] b_r,
  output logic [BW-1:0] a_data,
  output logic [BW-1:0] b_data,
  output logic          ready
);

  localparam int DEPTH = 1 << (2 * IW);
  localparam logic [IW-1:0] LAST = IW'(MAX_TOTAL);

  logic [BW-1:0] mem [DEPTH];

  logic          issuing;
  logic [IW-1:0] fn;
  logic [IW-1:0] fr;
  logic          wr_pend;
  logic [IW-1:0] wn;
  logic [IW-1:0] wcol;
  logic [BW-1:0] fill_prev;
  logic [BW-1:0] fill_val;
  logic [IW-1:0] fn_up;

  assign fn_up = fn - IW'(1);
  assign ready = !issuing && !wr_pend;

  // Row entry: left edge is one, row zero is zero elsewhere, else sum of the two above
  always_comb begin
    if (wcol == '0) begin
      fill_val = BW'(1);
    end else if (wn == '0) begin
      fill_val = '0;
    end else begin
      fill_val = a_data + fill_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b1;
      fn      <= '0;
      fr      <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= issuing;
      if (issuing) begin
        if (fr == LAST) begin
          fr <= '0;
          if (fn == LAST) begin
            issuing <= 1'b0;
          end else begin
            fn <= fn + IW'(1);
          end
        end else begin
          fr <= fr + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wn        <= fn;
    wcol      <= fr;
    fill_prev <= a_data;
    if (wr_pend) begin
      mem[{wn, wcol}] <= fill_val;
    end
    if (issuing) begin
      a_data <= mem[{fn_up, fr}];
    end else if (rd_en) begin
      a_data <= mem[{a_n, a_r}];
    end
    if (rd_en) begin
      b_data <= mem[{b_n, b_r}];
    end
  end

endmodule

// ===== rtl/hgti_seq.sv =====
// Microcode sequencer: step counter, control store and jump selection
`include "assert_macros.svh"

module hgti_seq import hgti_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  seq_flags_t flags,
  output step_t      pc,
  output dp_op_t     op
);

  uword_t word;
  logic   take;
  step_t  pc_next;

  assign word = ucode_rom(pc);
  assign op   = word.op;

  always_comb begin
    case (word.jump)
      JMP_NONE:       take = 1'b0;
      JMP_GOTO:       take = 1'b1;
      JMP_NO_ACCEPT:  take = !flags.accept;
      JMP_BAD:        take = flags.dp.bad;
      JMP_LO_ABOVE_S: take = flags.dp.lo_above_s;
      JMP_T_BELOW_S:  take = flags.dp.t_below_s;
      JMP_FITS:       take = flags.dp.fits;
      JMP_M_BELOW_L:  take = flags.dp.m_below_l;
      JMP_OUT_BUSY:   take = flags.out_busy;
      default:        take = 1'b0;
    endcase
    pc_next = take ? word.target : pc + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  `HGTI_ASSERT_NOW(a_pc_in_program, 1'b1, pc <= STEP_RET_BAD, "step counter left the program")

endmodule

// ===== rtl/hgti_dp.sv =====
// Datapath: query registers, shared 32x32 multiplier, accumulator and bound compare
module hgti_dp import hgti_pkg::*; #(
  parameter int MAX_TOTAL = 50,
  localparam int IW = $clog2(MAX_TOTAL + 1),
  localparam int BW = MAX_TOTAL
) (
  input  logic               clk,
  input  dp_op_t             op,
  input  logic               accept,
  input  hgti_in_t           query,
  input  logic [FIELD_W-1:0] pop,
  input  logic [FIELD_W-1:0] samp,
  input  logic [BW-1:0]      a_data,
  input  logic [BW-1:0]      b_data,
  output logic               rd_en,
  output logic [IW-1:0]      a_n,
  output logic [IW-1:0]      a_r,
  output logic [IW-1:0]      b_n,
  output logic [IW-1:0]      b_r,
  output dp_flags_t          flags,
  output logic [FIELD_W-1:0] m
);

  localparam int RW = BW + FRAC_W;

  logic [FIELD_W-1:0] s;
  logic [FRAC_W-1:0]  delta;
  logic               bad;
  logic [FIELD_W-1:0] t;
  logic [BW-1:0]      acc;
  logic [63:0]        prod;
  logic [RW-1:0]      rr;

  logic [FIELD_W-1:0] k;
  logic [FIELD_W-1:0] lo_t;
  logic [FIELD_W-1:0] a_n_full;
  logic [FIELD_W-1:0] a_r_full;
  logic [FIELD_W-1:0] b_n_full;
  logic [FIELD_W-1:0] b_r_full;
  logic [63:0]        a_ext;
  logic [63:0]        b_ext;
  logic [31:0]        mul_x;
  logic [31:0]        mul_y;
  logic [63:0]        mp;
  logic [95:0]        prod_sh;
  logic               bad_now;

  assign k     = pop - samp;
  assign lo_t  = (m > k) ? m - k : '0;
  assign a_ext = 64'(a_data);
  assign b_ext = 64'(b_data);
  assign mp    = mul_x * mul_y;
  assign prod_sh = {prod, 32'b0};

  assign bad_now = (pop > FIELD_W'(MAX_TOTAL)) || (samp > pop) ||
                   (query.success_count > samp);

  // Table addresses: the total count C(L,l) or the two factors of one term
  assign rd_en    = (op == OP_RD_TOTAL) || (op == OP_RD_TERM);
  assign a_n_full = (op == OP_RD_TOTAL) ? pop : m;
  assign a_r_full = (op == OP_RD_TOTAL) ? samp : t;
  assign b_n_full = pop - m;
  assign b_r_full = samp - t;
  assign a_n      = a_n_full[IW-1:0];
  assign a_r      = a_r_full[IW-1:0];
  assign b_n      = b_n_full[IW-1:0];
  assign b_r      = b_r_full[IW-1:0];

  assign flags.bad        = bad;
  assign flags.lo_above_s = lo_t > s;
  assign flags.t_below_s  = t < s;
  assign flags.fits       = {acc, 16'b0} <= rr;
  assign flags.m_below_l  = m < pop;

  always_comb begin
    case (op)
      OP_MUL_R_LO: begin
        mul_x = a_ext[31:0];
        mul_y = 32'(delta);
      end
      OP_MUL_R_HI: begin
        mul_x = a_ext[63:32];
        mul_y = 32'(delta);
      end
      OP_MUL_LL: begin
        mul_x = a_ext[31:0];
        mul_y = b_ext[31:0];
      end
      OP_MUL_LH: begin
        mul_x = a_ext[31:0];
        mul_y = b_ext[63:32];
      end
      OP_MUL_HL: begin
        mul_x = a_ext[63:32];
        mul_y = b_ext[31:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        if (accept) begin
          s     <= query.success_count;
          delta <= query.threshold_fraction;
          bad   <= bad_now;
        end
      end
      OP_MUL_R_LO: prod <= mp;
      OP_MUL_R_HI: begin
        rr   <= RW'(prod);
        prod <= mp;
      end
      OP_ACC_R: begin
        rr <= rr + prod_sh[RW-1:0];
        m  <= s;
      end
      OP_SUM_INIT: begin
        acc <= '0;
        t   <= lo_t;
      end
      OP_MUL_LL: prod <= mp;
      OP_MUL_LH: begin
        acc  <= acc + prod[BW-1:0];
        prod <= mp;
      end
      OP_MUL_HL: begin
        acc  <= acc + prod_sh[BW-1:0];
        prod <= mp;
      end
      OP_ACC_NEXT_T: begin
        acc <= acc + prod_sh[BW-1:0];
        t   <= t + FIELD_W'(1);
      end
      OP_INC_M: m <= m + FIELD_W'(1);
      default: ;
    endcase
  end

endmodule

// ===== rtl/hypergeometric_tail_inverse.sv =====
// Top level of the hypergeometric tail inverse block: config, handshakes, result register
// One query in flight: the scan tries m upward from s, each m summing terms(m) <= s + 1
// terms, and a bad query skips the scan; after the result loads, the sequencer passes its
// return step to idle before it takes the next query. The shared 32x32 multiplier serves
// three partial products per term.
// Reset: synchronous, clears control and loads population 50, sample 0, then fills the
// binomial memory, during which queries are stalled.
`include "assert_macros.svh"

module hypergeometric_tail_inverse import hgti_pkg::*; #(
  parameter int MAX_TOTAL = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 query_valid,
  output logic                 query_stall,
  input  hgti_in_t             query,
  output logic                 result_valid,
  input  logic                 result_stall,
  output hgti_out_t            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data
);

  localparam int IW = $clog2(MAX_TOTAL + 1);
  localparam int BW = MAX_TOTAL;

  // Configuration registers
  logic [FIELD_W-1:0] pop;
  logic [FIELD_W-1:0] samp;

  // Sequencer and datapath links
  step_t              pc;
  dp_op_t             op;
  seq_flags_t         flags;
  dp_flags_t          dp_flags;
  logic               accept;
  logic               out_busy;
  logic               load;
  logic               rom_ready;
  logic [FIELD_W-1:0] dp_m;

  // Binomial memory ports
  logic               rd_en;
  logic [IW-1:0]      a_n;
  logic [IW-1:0]      a_r;
  logic [IW-1:0]      b_n;
  logic [IW-1:0]      b_r;
  logic [BW-1:0]      a_data;
  logic [BW-1:0]      b_data;

  // Take a query only at the idle step once the table is filled
  assign query_stall = !((pc == STEP_IDLE) && rom_ready);
  assign accept      = query_valid && !query_stall;

  // The result register is free when empty or being drained this cycle
  assign out_busy = result_valid && result_stall;
  assign load     = ((op == OP_EMIT) || (op == OP_EMIT_BAD)) && !out_busy;

  assign flags.accept   = accept;
  assign flags.out_busy = out_busy;
  assign flags.dp       = dp_flags;

  // Configuration writes; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      pop  <= FIELD_W'(50);
      samp <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POP:    pop  <= cfg_data;
        REG_SAMPLE: samp <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register: hold a finished transaction until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (op == OP_EMIT_BAD) begin
        result.smallest_m <= '0;
        result.bad_query  <= 1'b1;
      end else begin
        result.smallest_m <= dp_m;
        result.bad_query  <= 1'b0;
      end
    end
  end

  hgti_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .pc    (pc),
    .op    (op)
  );

  hgti_dp #(
    .MAX_TOTAL (MAX_TOTAL)
  ) u_dp (
    .clk    (clk),
    .op     (op),
    .accept (accept),
    .query  (query),
    .pop    (pop),
    .samp   (samp),
    .a_data (a_data),
    .b_data (b_data),
    .rd_en  (rd_en),
    .a_n    (a_n),
    .a_r    (a_r),
    .b_n    (b_n),
    .b_r    (b_r),
    .flags  (dp_flags),
    .m      (dp_m)
  );

  hgti_binom_rom #(
    .MAX_TOTAL (MAX_TOTAL)
  ) u_rom (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .a_n    (a_n),
    .a_r    (a_r),
    .b_n    (b_n),
    .b_r    (b_r),
    .a_data (a_data),
    .b_data (b_data),
    .ready  (rom_ready)
  );

  `HGTI_ASSERT_NEXT(a_accept_starts_check, accept, pc == STEP_CHECK, "query taken but sequencer did not start")
  `HGTI_ASSERT_NOW(a_bad_has_zero_m, result_valid && result.bad_query, result.smallest_m == '0, "bad result carries nonzero m")
  `HGTI_ASSERT_NOW(a_m_within_range, load && (op == OP_EMIT), {1'b0, dp_m} <= ({1'b0, pop} + 7'd1), "result m beyond population plus one")

endmodule
